// File: hdl/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types, widths and constants of the multichannel downmix unit.
// ----------------------------------------------------------------------------
package dmx_pkg;

    localparam int SAMPLE_W     = 32;   // raw channel sample
    localparam int NUM_SLOTS    = 8;    // channel fields on the input stream
    localparam int MAX_CH_DEF   = 8;
    localparam int FMT_W        = 3;
    localparam int CNT_W        = 4;
    localparam int OUT_W        = 16;
    localparam int LANE_W       = 40;   // Q8.31 plus sign
    localparam int SUM_W        = 43;   // sum of eight lanes
    localparam int MAG_W        = 34;   // magnitude below n * 2^31
    localparam int FRAC_W       = 31;
    localparam int SCALE_W      = 15;   // shift for the * 32767 step
    localparam int T_W          = 18;   // scaled magnitude / 2^31
    localparam int RECIP_SH     = 21;
    localparam int RECIP_W      = 22;
    localparam int Q_W          = 15;
    localparam int APB_DW       = 32;
    localparam int APB_AW       = 3;

    // sample formats
    localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
    localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_S32 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_F32 = 3'd3;

    // register indexes (paddr[2])
    localparam logic REG_FORMAT = 1'b0;
    localparam logic REG_COUNT  = 1'b1;

    localparam logic [FMT_W-1:0] FORMAT_RST = FMT_S16;
    localparam logic [CNT_W-1:0] COUNT_RST  = 4'd1;

    localparam logic signed [OUT_W-1:0] FULL_POS = 16'sd32767;
    localparam logic signed [OUT_W-1:0] FULL_NEG = -16'sd32767;

    // floor(2^21 / n) for n = 1..8, unused codes zero
    localparam logic [RECIP_W-1:0] RECIP_TBL [16] = '{
        22'd0,      22'd2097152, 22'd1048576, 22'd699050,
        22'd524288, 22'd419430,  22'd349525,  22'd299593,
        22'd262144, 22'd0,       22'd0,       22'd0,
        22'd0,      22'd0,       22'd0,       22'd0
    };

    typedef logic signed [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic             sat_pos;
        logic             sat_neg;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_mag;

endpackage

// File: hdl/dmx_lane.sv
// ----------------------------------------------------------------------------
// dmx_lane
// One channel lane: decode raw sample bits into a registered Q8.31 value.
// ----------------------------------------------------------------------------
module dmx_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [dmx_pkg::FMT_W-1:0]     i_fmt,
    input  logic [dmx_pkg::SAMPLE_W-1:0]  i_raw,
    output dmx_pkg::t_lane                o_lane
);

    localparam int FMAG_W = dmx_pkg::LANE_W - 1;

    logic [7:0]          w_exp;
    logic [23:0]         w_full;
    logic [7:0]          w_rsh;
    logic [FMAG_W-1:0]   w_fmag;
    dmx_pkg::t_lane      w_flane;
    dmx_pkg::t_lane      n_lane;
    dmx_pkg::t_lane      r_lane;

    // IEEE single to Q8.31, truncated toward zero, saturated at 2^38
    always_comb begin
        w_exp  = i_raw[30:23];
        w_full = {1'b1, i_raw[22:0]};
        w_rsh  = 8'd119 - w_exp;
        w_fmag = '0;
        if (w_exp == 8'hFF) begin
            w_fmag = (i_raw[22:0] != '0) ? '0 : FMAG_W'(1) << 38;
        end else if (w_exp == 8'd0) begin
            w_fmag = '0;
        end else if (w_exp >= 8'd134) begin
            w_fmag = FMAG_W'(1) << 38;
        end else if (w_exp >= 8'd119) begin
            w_fmag = FMAG_W'(w_full) << (w_exp - 8'd119);
        end else if (w_rsh < 8'd24) begin
            w_fmag = FMAG_W'(w_full >> w_rsh[4:0]);
        end
        w_flane = i_raw[31] ? -dmx_pkg::t_lane'({1'b0, w_fmag})
                            : dmx_pkg::t_lane'({1'b0, w_fmag});
    end

    always_comb begin
        unique case (i_fmt)
            dmx_pkg::FMT_U8:  n_lane = {{8{~i_raw[7]}}, ~i_raw[7], i_raw[6:0], 24'd0};
            dmx_pkg::FMT_S16: n_lane = {{8{i_raw[15]}}, i_raw[15:0], 16'd0};
            dmx_pkg::FMT_S32: n_lane = {{8{i_raw[31]}}, i_raw};
            dmx_pkg::FMT_F32: n_lane = w_flane;
            default:          n_lane = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// File: hdl/dmx_merge.sv
// ----------------------------------------------------------------------------
// dmx_merge
// Registered adder tree over the lanes in use, then clamp test and magnitude.
// ----------------------------------------------------------------------------
module dmx_merge #(
    parameter int MAX_CHANNELS = dmx_pkg::MAX_CH_DEF
) (
    input  logic                       i_clk,
    input  logic [3:0]                 i_en,     // tree level 1..3, clamp stage
    input  logic [dmx_pkg::CNT_W-1:0]  i_n,
    input  dmx_pkg::t_lane             i_lanes [MAX_CHANNELS],
    output dmx_pkg::t_mag              o_mag
);

    localparam int W1 = dmx_pkg::LANE_W + 1;
    localparam int W2 = dmx_pkg::LANE_W + 2;

    dmx_pkg::t_lane                  w_lane [dmx_pkg::NUM_SLOTS];
    logic signed [W1-1:0]            r_s1 [4];
    logic signed [W2-1:0]            r_s2 [2];
    logic signed [dmx_pkg::SUM_W-1:0] r_sum;
    logic signed [dmx_pkg::SUM_W-1:0] w_limit;
    logic signed [dmx_pkg::SUM_W-1:0] w_abs;
    dmx_pkg::t_mag                   n_mag;
    dmx_pkg::t_mag                   r_mag;

    // drop lanes beyond the channel count
    for (genvar g = 0; g < dmx_pkg::NUM_SLOTS; g++) begin : g_mask
        if (g < MAX_CHANNELS) begin : g_used
            assign w_lane[g] = (dmx_pkg::CNT_W'(g) < i_n) ? i_lanes[g] : '0;
        end else begin : g_pad
            assign w_lane[g] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            for (int k = 0; k < 4; k++) begin
                r_s1[k] <= W1'(w_lane[2*k]) + W1'(w_lane[2*k+1]);
            end
        end
        if (i_en[1]) begin
            for (int k = 0; k < 2; k++) begin
                r_s2[k] <= W2'(r_s1[2*k]) + W2'(r_s1[2*k+1]);
            end
        end
        if (i_en[2]) begin
            r_sum <= dmx_pkg::SUM_W'(r_s2[0]) + dmx_pkg::SUM_W'(r_s2[1]);
        end
        if (i_en[3]) begin
            r_mag <= n_mag;
        end
    end

    always_comb begin
        w_limit       = {8'd0, i_n, 31'd0};
        w_abs         = r_sum[dmx_pkg::SUM_W-1] ? -r_sum : r_sum;
        n_mag.sat_pos = (r_sum >= w_limit);
        n_mag.sat_neg = (r_sum <= -w_limit);
        n_mag.neg     = r_sum[dmx_pkg::SUM_W-1];
        n_mag.mag     = w_abs[dmx_pkg::MAG_W-1:0];
    end

    assign o_mag = r_mag;

endmodule

// File: hdl/dmx_scale.sv
// ----------------------------------------------------------------------------
// dmx_scale
// Mean times 32767, truncated: scale, divide by channel count, sign, output.
// ----------------------------------------------------------------------------
module dmx_scale (
    input  logic                          i_clk,
    input  logic [2:0]                    i_en,
    input  logic [dmx_pkg::CNT_W-1:0]     i_n,
    input  dmx_pkg::t_mag                 i_mag,
    output logic signed [dmx_pkg::OUT_W-1:0] o_sample
);

    localparam int P_W    = dmx_pkg::MAG_W + dmx_pkg::SCALE_W;
    localparam int PROD_W = dmx_pkg::T_W + dmx_pkg::RECIP_W;
    localparam int REM_W  = dmx_pkg::T_W + 1;

    logic [P_W-1:0]                   w_p;
    logic [PROD_W-1:0]                w_prod;
    logic [REM_W-1:0]                 w_qn;
    logic [REM_W-1:0]                 w_rem;
    logic [dmx_pkg::OUT_W-1:0]        w_q;
    logic signed [dmx_pkg::OUT_W-1:0] n_sample;

    logic [dmx_pkg::T_W-1:0]          r_t5;
    logic [2:0]                       r_flg5;   // sat_pos, sat_neg, neg
    logic [dmx_pkg::T_W-1:0]          r_t6;
    logic [dmx_pkg::Q_W-1:0]          r_q6;
    logic [2:0]                       r_flg6;
    logic signed [dmx_pkg::OUT_W-1:0] r_sample;

    always_comb begin
        // mag * 32767, then drop the 2^31 of Q8.31
        w_p    = {i_mag.mag, 15'd0} - P_W'(i_mag.mag);
        // quotient estimate by reciprocal, low by at most one
        w_prod = PROD_W'(r_t5) * PROD_W'(dmx_pkg::RECIP_TBL[i_n]);
        w_qn   = REM_W'(r_q6) * REM_W'(i_n);
        w_rem  = REM_W'(r_t6) - w_qn;
        w_q    = (w_rem >= REM_W'(i_n)) ? dmx_pkg::OUT_W'(r_q6) + 16'd1
                                        : dmx_pkg::OUT_W'(r_q6);
        priority if (r_flg6[2]) begin
            n_sample = dmx_pkg::FULL_POS;
        end else if (r_flg6[1]) begin
            n_sample = dmx_pkg::FULL_NEG;
        end else if (r_flg6[0]) begin
            n_sample = -signed'(w_q);
        end else begin
            n_sample = signed'(w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t5   <= w_p[P_W-1:dmx_pkg::FRAC_W];
            r_flg5 <= {i_mag.sat_pos, i_mag.sat_neg, i_mag.neg};
        end
        if (i_en[1]) begin
            r_t6   <= r_t5;
            r_q6   <= w_prod[dmx_pkg::RECIP_SH +: dmx_pkg::Q_W];
            r_flg6 <= r_flg5;
        end
        if (i_en[2]) begin
            r_sample <= n_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

// File: hdl/multichannel_downmix_to_int16_unit.sv
// ----------------------------------------------------------------------------
// multichannel_downmix_to_int16_unit
// Downmix of one multichannel PCM frame to one mono signed 16-bit sample.
// ----------------------------------------------------------------------------
// One frame transaction is taken per clock while the pipeline can advance, and
// one mono sample comes out per frame. Each channel has its own decode lane,
// a three-level registered adder tree merges the lanes, and a reciprocal
// multiply divides by the channel count; every pipeline stage holds one
// frame, and a stalled output only stops the input once all eight stages are
// full. Write the format and channel count through the APB port while no
// frame is in flight.
module multichannel_downmix_to_int16_unit #(
    parameter int MAX_CHANNELS = dmx_pkg::MAX_CH_DEF
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // stream in, tdata: sample_0 [31:0] .. sample_7 [255:224]
    input  logic                                          i_s_tvalid,
    output logic                                          o_s_tready,
    input  logic [dmx_pkg::NUM_SLOTS*dmx_pkg::SAMPLE_W-1:0] i_s_tdata,
    // stream out, tdata: mono_sample [15:0]
    output logic                                          o_m_tvalid,
    input  logic                                          i_m_tready,
    output logic [dmx_pkg::OUT_W-1:0]                     o_m_tdata,
    // APB configuration
    input  logic                                          i_psel,
    input  logic                                          i_penable,
    input  logic                                          i_pwrite,
    input  logic [dmx_pkg::APB_AW-1:0]                    i_paddr,
    input  logic [dmx_pkg::APB_DW-1:0]                    i_pwdata,
    output logic [dmx_pkg::APB_DW-1:0]                    o_prdata,
    output logic                                          o_pready
);

    localparam int NUM_STG = 8;

    logic [dmx_pkg::FMT_W-1:0]        r_format;
    logic [dmx_pkg::CNT_W-1:0]        r_count;
    logic [dmx_pkg::CNT_W-1:0]        w_n;
    logic                             w_wr;
    logic [NUM_STG-1:0]               r_vld;
    logic [NUM_STG-1:0]               w_adv;
    dmx_pkg::t_lane                   w_lanes [MAX_CHANNELS];
    dmx_pkg::t_mag                    w_mag;
    logic signed [dmx_pkg::OUT_W-1:0] w_sample;

    // configuration registers
    assign w_wr     = i_psel & i_penable & i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= dmx_pkg::FORMAT_RST;
            r_count  <= dmx_pkg::COUNT_RST;
        end else if (w_wr) begin
            unique case (i_paddr[2])
                dmx_pkg::REG_FORMAT: r_format <= i_pwdata[dmx_pkg::FMT_W-1:0];
                dmx_pkg::REG_COUNT:  r_count  <= i_pwdata[dmx_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            dmx_pkg::REG_FORMAT: o_prdata = dmx_pkg::APB_DW'(r_format);
            dmx_pkg::REG_COUNT:  o_prdata = dmx_pkg::APB_DW'(r_count);
            default:             o_prdata = '0;
        endcase
    end

    // zero count means one channel, large counts saturate
    always_comb begin
        priority if (r_count == '0) begin
            w_n = dmx_pkg::CNT_W'(1);
        end else if (r_count > dmx_pkg::CNT_W'(MAX_CHANNELS)) begin
            w_n = dmx_pkg::CNT_W'(MAX_CHANNELS);
        end else begin
            w_n = r_count;
        end
    end

    // a stage advances when it is empty or the next one advances
    always_comb begin
        w_adv[NUM_STG-1] = ~r_vld[NUM_STG-1] | i_m_tready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            w_adv[k] = ~r_vld[k] | w_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NUM_STG; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_adv[0];

    for (genvar g = 0; g < MAX_CHANNELS; g++) begin : g_lane
        dmx_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (w_adv[0]),
            .i_fmt  (r_format),
            .i_raw  (i_s_tdata[g*dmx_pkg::SAMPLE_W +: dmx_pkg::SAMPLE_W]),
            .o_lane (w_lanes[g])
        );
    end

    dmx_merge #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_en    (w_adv[4:1]),
        .i_n     (w_n),
        .i_lanes (w_lanes),
        .o_mag   (w_mag)
    );

    dmx_scale u_scale (
        .i_clk    (i_clk),
        .i_en     (w_adv[7:5]),
        .i_n      (w_n),
        .i_mag    (w_mag),
        .o_sample (w_sample)
    );

    assign o_m_tvalid = r_vld[NUM_STG-1];
    assign o_m_tdata  = w_sample;

endmodule
